FILE: rtl/core/stmm_pkg.sv
// Shared types and constants of the sparse triple matrix multiply block.
// Holds the payload words, pipeline tags, state encoding and request codes.
// No dependencies.
`default_nettype none

package stmm_pkg;

    localparam int ROW_W    = 3;
    localparam int ELEM_W   = 16;
    localparam int SUM_W    = 32;
    localparam int REQ_W    = 2;
    localparam int CFG_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Request codes of the input word.
    localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MULT   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_COL_B = 2'd2;
    localparam logic [CFG_W-1:0]     CFG_RESET_VAL  = 3'd7;

    // A value of zero marks an absent entry.
    localparam logic [ELEM_W-1:0] EMPTY_SET = '0;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [ROW_W-1:0]         row_index;
        logic [ROW_W-1:0]         col_index;
        logic signed [ELEM_W-1:0] elem_value;
    } stmm_in_t;

    typedef struct packed {
        logic [ROW_W-1:0]        out_row;
        logic [ROW_W-1:0]        out_col;
        logic signed [SUM_W-1:0] out_value;
        logic                    last_entry;
        logic                    no_nonzero;
    } stmm_out_t;

    // Tag that travels with one multiply-accumulate step.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
    } stmm_tag_t;

    // Finished product entry leaving the multiply-accumulate unit.
    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [SUM_W-1:0] value;
    } stmm_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } stmm_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/stmm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module stmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/stmm_store.sv
// One matrix store: a RAM plus one valid bit per entry, so that a clear wipes every entry at once.
// An entry that is not valid reads as zero. Depends on stmm_ram.
`default_nettype none

module stmm_store #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     clear,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [DEPTH-1:0] valid_reg, valid_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [WIDTH-1:0] ram_q;

    stmm_ram #(
        .WIDTH(WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_comb begin
        valid_next = valid_reg;
        if (clear) begin
            valid_next = '0;
        end else if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
        rd_valid_next = rd_en ? valid_reg[rd_addr] : rd_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign rd_data = rd_valid_reg ? ram_q : '0;

    // The sequencer never writes an entry in the cycle that wipes the store.
    assert property (@(posedge aclk) disable iff (!aresetn) clear |-> !wr_en)
        else $error("store written during clear");

endmodule

`default_nettype wire

FILE: rtl/core/stmm_mac.sv
// Shared multiply-accumulate unit: a registered product, then a 32-bit accumulate.
// Depends on stmm_pkg for the tag and result types.
`default_nettype none

module stmm_mac
    import stmm_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         adv,
    input  wire stmm_tag_t                    tag_in,
    input  wire logic signed [VALUE_BITS-1:0] a_data,
    input  wire logic signed [VALUE_BITS-1:0] b_data,
    output logic                              busy,
    output stmm_res_t                         res
);

    logic signed [2*VALUE_BITS-1:0] prod_full;
    logic [SUM_W-1:0]               prod_reg, prod_next;
    logic [SUM_W-1:0]               acc_reg, acc_next;
    logic [SUM_W-1:0]               sum;
    stmm_tag_t                      tag_reg, tag_next;

    assign prod_full = a_data * b_data;

    always_comb begin
        prod_next = prod_reg;
        tag_next  = tag_reg;
        acc_next  = acc_reg;
        // The first step of each product entry starts the sum afresh.
        sum = (tag_reg.first ? '0 : acc_reg) + prod_reg;
        if (adv) begin
            prod_next = SUM_W'(prod_full);
            tag_next  = tag_in;
            if (tag_reg.valid) begin
                acc_next = sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign busy      = tag_reg.valid;
    assign res.hit   = adv && tag_reg.valid && tag_reg.last && (sum != '0);
    assign res.row   = tag_reg.row;
    assign res.col   = tag_reg.col;
    assign res.value = sum;

endmodule

`default_nettype wire

FILE: rtl/core/sparse_triple_matrix_multiply.sv
// Sparse triple matrix multiply: load words deposit (row, column, value) triples of A
// or B, a multiply word emits the nonzero entries of C = A x B row-major, the last one
// marked, or a single empty-flagged word when C has none. A load that is kept reads the
// addressed store and then writes the sum back in ST_LOAD_WR; a dropped load is only
// accepted. A multiply issues one step of the single multiply-accumulate unit per
// (row, column, inner) index within the limits, then drains the pipeline and finishes,
// and waits while the result side holds off. Both stores clear together at the end of a
// multiply through per-entry valid bits, so there is no clearing pass after reset.
// Depends on stmm_pkg, stmm_store, stmm_ram and stmm_mac.
`default_nettype none

module sparse_triple_matrix_multiply
    import stmm_pkg::*;
#(
    parameter int DIM        = 8,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire stmm_in_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output stmm_out_t                 m_data
);

    localparam int DEPTH  = DIM * DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(DIM);
    localparam logic [ROW_W-1:0] MAX_IDX = ROW_W'(DIM - 1);

    stmm_state_t state_reg, state_next;

    logic [CFG_W-1:0] last_row_a_reg, last_inner_reg, last_col_b_reg;
    logic [IDX_W-1:0] lim_r, lim_i, lim_c;

    logic [IDX_W-1:0] row_ctr_reg, row_ctr_next;
    logic [IDX_W-1:0] col_ctr_reg, col_ctr_next;
    logic [IDX_W-1:0] inner_ctr_reg, inner_ctr_next;

    logic                  ld_sel_b_reg, ld_sel_b_next;
    logic [ADDR_W-1:0]     ld_addr_reg, ld_addr_next;
    logic [VALUE_BITS-1:0] ld_val_reg, ld_val_next;

    stmm_tag_t tag1_reg, tag1_next;
    stmm_out_t out_reg, out_next;
    stmm_out_t pend_reg, pend_next;
    logic      m_valid_reg, m_valid_next;
    logic      pend_valid_reg, pend_valid_next;

    logic                  accept, is_load, is_b, ld_ok, ld_rd;
    logic                  adv, issue, ld_wr, fin_fire, last_step;
    logic [ROW_W-1:0]      chk_r, chk_c;
    logic signed [31:0]    elem_ext;
    logic [ADDR_W-1:0]     in_addr, a_run_addr, b_run_addr;
    logic                  a_rd_en, b_rd_en;
    logic [ADDR_W-1:0]     a_rd_addr, b_rd_addr;
    logic [VALUE_BITS-1:0] a_q, b_q, ld_old, ld_sum;
    logic                  mac_busy;
    stmm_res_t             res;

    // Configuration registers and their clamped limits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_row_a_reg <= CFG_RESET_VAL;
            last_inner_reg <= CFG_RESET_VAL;
            last_col_b_reg <= CFG_RESET_VAL;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_LAST_ROW_A: last_row_a_reg <= cfg_wdata;
                CFG_LAST_INNER: last_inner_reg <= cfg_wdata;
                CFG_LAST_COL_B: last_col_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign lim_r = (last_row_a_reg > MAX_IDX) ? IDX_W'(DIM - 1) : IDX_W'(last_row_a_reg);
    assign lim_i = (last_inner_reg > MAX_IDX) ? IDX_W'(DIM - 1) : IDX_W'(last_inner_reg);
    assign lim_c = (last_col_b_reg > MAX_IDX) ? IDX_W'(DIM - 1) : IDX_W'(last_col_b_reg);

    // Load decode.
    assign accept  = s_valid && s_ready;
    assign is_b    = (s_data.req_type == REQ_LOAD_B);
    assign is_load = (s_data.req_type == REQ_LOAD_A) || is_b;
    assign chk_r   = is_b ? ROW_W'(lim_i) : ROW_W'(lim_r);
    assign chk_c   = is_b ? ROW_W'(lim_c) : ROW_W'(lim_i);
    assign ld_ok   = is_load && (s_data.elem_value != EMPTY_SET)
                     && (s_data.row_index <= chk_r) && (s_data.col_index <= chk_c);
    assign elem_ext = 32'(s_data.elem_value);
    assign in_addr  = ADDR_W'(s_data.row_index) * ADDR_W'(DIM) + ADDR_W'(s_data.col_index);

    assign a_run_addr = ADDR_W'(row_ctr_reg) * ADDR_W'(DIM) + ADDR_W'(inner_ctr_reg);
    assign b_run_addr = ADDR_W'(inner_ctr_reg) * ADDR_W'(DIM) + ADDR_W'(col_ctr_reg);
    assign last_step  = (inner_ctr_reg == lim_i) && (col_ctr_reg == lim_c)
                        && (row_ctr_reg == lim_r);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.req_type == REQ_MULT) begin
                    state_next = ST_RUN;
                end else if (accept && ld_ok) begin
                    state_next = ST_LOAD_WR;
                end
            end
            ST_LOAD_WR: state_next = ST_IDLE;
            ST_RUN: begin
                if (issue && last_step) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!tag1_reg.valid && !mac_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (fin_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        // The multiply pipeline holds while a finished word waits at the output.
        adv      = !(m_valid_reg && !m_ready);
        issue    = (state_reg == ST_RUN) && adv;
        ld_rd    = (state_reg == ST_IDLE) && s_valid && ld_ok;
        ld_wr    = (state_reg == ST_LOAD_WR);
        fin_fire = (state_reg == ST_FINISH) && adv;
        a_rd_en   = issue || (ld_rd && !is_b);
        b_rd_en   = issue || (ld_rd && is_b);
        a_rd_addr = issue ? a_run_addr : in_addr;
        b_rd_addr = issue ? b_run_addr : in_addr;
    end

    // Counters, load holding registers and the step tag.
    always_comb begin
        row_ctr_next   = row_ctr_reg;
        col_ctr_next   = col_ctr_reg;
        inner_ctr_next = inner_ctr_reg;
        ld_sel_b_next  = ld_sel_b_reg;
        ld_addr_next   = ld_addr_reg;
        ld_val_next    = ld_val_reg;
        tag1_next      = tag1_reg;
        if (accept) begin
            row_ctr_next   = '0;
            col_ctr_next   = '0;
            inner_ctr_next = '0;
            ld_sel_b_next  = is_b;
            ld_addr_next   = in_addr;
            ld_val_next    = elem_ext[VALUE_BITS-1:0];
        end
        if (adv) begin
            tag1_next.valid = issue;
            tag1_next.first = (inner_ctr_reg == '0);
            tag1_next.last  = (inner_ctr_reg == lim_i);
            tag1_next.row   = ROW_W'(row_ctr_reg);
            tag1_next.col   = ROW_W'(col_ctr_reg);
        end
        if (issue) begin
            if (inner_ctr_reg == lim_i) begin
                inner_ctr_next = '0;
                if (col_ctr_reg == lim_c) begin
                    col_ctr_next = '0;
                    row_ctr_next = row_ctr_reg + 1'b1;
                end else begin
                    col_ctr_next = col_ctr_reg + 1'b1;
                end
            end else begin
                inner_ctr_next = inner_ctr_reg + 1'b1;
            end
        end
    end

    // One finished entry is held back so that the last one can be marked.
    always_comb begin
        out_next        = out_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        if (res.hit) begin
            if (pend_valid_reg) begin
                out_next     = pend_reg;
                m_valid_next = 1'b1;
            end
            pend_next.out_row    = res.row;
            pend_next.out_col    = res.col;
            pend_next.out_value  = res.value;
            pend_next.last_entry = 1'b0;
            pend_next.no_nonzero = 1'b0;
            pend_valid_next      = 1'b1;
        end
        if (fin_fire) begin
            if (pend_valid_reg) begin
                out_next            = pend_reg;
                out_next.last_entry = 1'b1;
            end else begin
                out_next            = '0;
                out_next.last_entry = 1'b1;
                out_next.no_nonzero = 1'b1;
            end
            m_valid_next    = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            row_ctr_reg    <= '0;
            col_ctr_reg    <= '0;
            inner_ctr_reg  <= '0;
            tag1_reg       <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_ctr_reg    <= row_ctr_next;
            col_ctr_reg    <= col_ctr_next;
            inner_ctr_reg  <= inner_ctr_next;
            tag1_reg       <= tag1_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ld_sel_b_reg <= ld_sel_b_next;
        ld_addr_reg  <= ld_addr_next;
        ld_val_reg   <= ld_val_next;
        out_reg      <= out_next;
        pend_reg     <= pend_next;
    end

    assign ld_old = ld_sel_b_reg ? b_q : a_q;
    assign ld_sum = ld_old + ld_val_reg;

    stmm_store #(
        .WIDTH(VALUE_BITS),
        .DEPTH(DEPTH)
    ) u_store_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (fin_fire),
        .wr_en   (ld_wr && !ld_sel_b_reg),
        .wr_addr (ld_addr_reg),
        .wr_data (ld_sum),
        .rd_en   (a_rd_en),
        .rd_addr (a_rd_addr),
        .rd_data (a_q)
    );

    stmm_store #(
        .WIDTH(VALUE_BITS),
        .DEPTH(DEPTH)
    ) u_store_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (fin_fire),
        .wr_en   (ld_wr && ld_sel_b_reg),
        .wr_addr (ld_addr_reg),
        .wr_data (ld_sum),
        .rd_en   (b_rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_q)
    );

    stmm_mac #(
        .VALUE_BITS(VALUE_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .tag_in  (tag1_reg),
        .a_data  (a_q),
        .b_data  (b_q),
        .busy    (mac_busy),
        .res     (res)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        fin_fire |=> m_valid && m_data.last_entry)
        else $error("finished multiply did not present a last word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.no_nonzero |-> m_data.last_entry && m_data.out_value == '0)
        else $error("empty-product word malformed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.no_nonzero |-> m_data.out_value != '0)
        else $error("zero entry emitted");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !tag1_reg.valid && !mac_busy && !pend_valid_reg)
        else $error("pipeline not empty while idle");

endmodule

`default_nettype wire

FILE: bench/stmm_product_checker.sv
// Checker for the sparse triple matrix multiply block: it watches the configuration port and
// both word channels, keeps its own copy of the A and B stores, predicts the product words and
// compares them in order. Depends on stmm_pkg only.
module stmm_product_checker
    import stmm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  stmm_in_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  stmm_out_t            m_data,
    output int                   mismatch_count,
    output int                   words_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM = 8;

    logic signed [ELEM_W-1:0] a_cells [DIM*DIM];
    logic signed [ELEM_W-1:0] b_cells [DIM*DIM];
    logic [CFG_W-1:0]         row_lim;
    logic [CFG_W-1:0]         inner_lim;
    logic [CFG_W-1:0]         col_lim;
    stmm_out_t                product_q [$];
    stmm_out_t                oldest;

    initial begin
        mismatch_count = 0;
        words_owed     = 0;
    end

    task automatic report(input string msg);
        $display("%0t checker mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [SUM_W-1:0] got,
                               input logic [SUM_W-1:0] want);
        if (got !== want) begin
            report($sformatf("%s is %0h, expected %0h (row %0d col %0d)",
                             name, got, want, oldest.out_row, oldest.out_col));
        end
    endtask

    task automatic clear_stores();
        for (int i = 0; i < DIM*DIM; i++) begin
            a_cells[i] = '0;
            b_cells[i] = '0;
        end
    endtask

    // Loads outside the configured shape are dropped; repeated positions add and wrap.
    task automatic deposit_triple(input bit into_b, input stmm_in_t w);
        logic [CFG_W-1:0] lim_r;
        logic [CFG_W-1:0] lim_c;
        int               slot;
        lim_r = into_b ? inner_lim : row_lim;
        lim_c = into_b ? col_lim : inner_lim;
        slot  = int'(w.row_index) * DIM + int'(w.col_index);
        if (w.elem_value != EMPTY_SET && w.row_index <= lim_r && w.col_index <= lim_c) begin
            if (into_b) begin
                b_cells[slot] = b_cells[slot] + w.elem_value;
            end else begin
                a_cells[slot] = a_cells[slot] + w.elem_value;
            end
        end
    endtask

    // Walks C row-major and queues every nonzero entry; an all-zero product gives one
    // word with the empty flag. Both stores are cleared afterwards.
    task automatic form_product();
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] term;
        stmm_out_t               entry;
        int                      found;
        found = 0;
        for (int r = 0; r <= int'(row_lim); r++) begin
            for (int c = 0; c <= int'(col_lim); c++) begin
                acc = '0;
                for (int k = 0; k <= int'(inner_lim); k++) begin
                    term = a_cells[r*DIM + k] * b_cells[k*DIM + c];
                    acc  = acc + term;
                end
                if (acc != '0) begin
                    entry.out_row    = r[ROW_W-1:0];
                    entry.out_col    = c[ROW_W-1:0];
                    entry.out_value  = acc;
                    entry.last_entry = 1'b0;
                    entry.no_nonzero = 1'b0;
                    product_q.push_back(entry);
                    found++;
                end
            end
        end
        if (found == 0) begin
            entry            = '0;
            entry.last_entry = 1'b1;
            entry.no_nonzero = 1'b1;
            product_q.push_back(entry);
        end else begin
            entry            = product_q.pop_back();
            entry.last_entry = 1'b1;
            product_q.push_back(entry);
        end
        clear_stores();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_stores();
            row_lim   = CFG_RESET_VAL;
            inner_lim = CFG_RESET_VAL;
            col_lim   = CFG_RESET_VAL;
            product_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_LAST_ROW_A: row_lim   = cfg_wdata;
                    CFG_LAST_INNER: inner_lim = cfg_wdata;
                    CFG_LAST_COL_B: col_lim   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_data.req_type)
                    REQ_LOAD_A: deposit_triple(1'b0, s_data);
                    REQ_LOAD_B: deposit_triple(1'b1, s_data);
                    REQ_MULT:   form_product();
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (product_q.size() == 0) begin
                    report($sformatf("result word row %0d col %0d value %0h with none expected",
                                     m_data.out_row, m_data.out_col, m_data.out_value));
                end else begin
                    oldest = product_q.pop_front();
                    check_field("out_row", SUM_W'(m_data.out_row), SUM_W'(oldest.out_row));
                    check_field("out_col", SUM_W'(m_data.out_col), SUM_W'(oldest.out_col));
                    check_field("out_value", m_data.out_value, oldest.out_value);
                    check_field("last_entry", SUM_W'(m_data.last_entry),
                                SUM_W'(oldest.last_entry));
                    check_field("no_nonzero", SUM_W'(m_data.no_nonzero),
                                SUM_W'(oldest.no_nonzero));
                end
            end
        end
        words_owed = product_q.size();
    end

endmodule

FILE: bench/tb_sparse_triple_matrix_multiply.sv
// Testbench top for the sparse triple matrix multiply block: it drives configuration and
// triple/multiply words with bursty timing, stalls the result side, and gives the verdict.
// Depends on stmm_pkg, the block itself and stmm_product_checker.
module tb_sparse_triple_matrix_multiply;
    timeunit 1ns;
    timeprecision 1ps;

    import stmm_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int IN_W          = $bits(stmm_in_t);
    localparam int RANDOM_WORK   = 450;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 1200;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    stmm_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    stmm_out_t            m_data;

    int                   mismatches;
    int                   outstanding;
    int                   cycle_cnt = 0;
    int                   hold_req_cnt = 0;
    int                   burst_left = 0;
    int                   work_done = 0;
    logic [CFG_W-1:0]     cur_lr;
    logic [CFG_W-1:0]     cur_li;
    logic [CFG_W-1:0]     cur_lc;
    stmm_in_t             prev_load;
    bit                   have_prev = 1'b0;

    sparse_triple_matrix_multiply u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    stmm_product_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatches),
        .words_owed     (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_sparse_triple_matrix_multiply: done, errors");
            $finish;
        end
    end

    function automatic stmm_in_t mk(input logic [REQ_W-1:0] req, input int row, input int col,
                                    input int val);
        stmm_in_t w;
        w.req_type   = req;
        w.row_index  = row[ROW_W-1:0];
        w.col_index  = col[ROW_W-1:0];
        w.elem_value = val[ELEM_W-1:0];
        return w;
    endfunction

    // Only words that change the stores or start a multiply count toward the item total.
    function automatic bit counts_as_work(input stmm_in_t w);
        case (w.req_type)
            REQ_MULT:   return 1'b1;
            REQ_LOAD_A: return w.elem_value != EMPTY_SET && w.row_index <= cur_lr &&
                               w.col_index <= cur_li;
            REQ_LOAD_B: return w.elem_value != EMPTY_SET && w.row_index <= cur_li &&
                               w.col_index <= cur_lc;
            default:    return 1'b0;
        endcase
    endfunction

    // Sends one word; between bursts the valid line may drop for a random gap.
    task automatic offer(input stmm_in_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (counts_as_work(w)) work_done++;
    endtask

    // Registers change only once every expected word is out and the last load has settled.
    task automatic configure(input logic [CFG_W-1:0] lr, input logic [CFG_W-1:0] li,
                             input logic [CFG_W-1:0] lc);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_LAST_ROW_A;
        cfg_wdata <= lr;
        @(posedge aclk);
        cfg_addr  <= CFG_LAST_INNER;
        cfg_wdata <= li;
        @(posedge aclk);
        cfg_addr  <= CFG_LAST_COL_B;
        cfg_wdata <= lc;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_lr    = lr;
        cur_li    = li;
        cur_lc    = lc;
        have_prev = 1'b0;
    endtask

    task automatic make_load(input bit a_only, output stmm_in_t w);
        int pick;
        int mag;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            w          = stmm_in_t'(IN_W'($urandom()));
            w.req_type = REQ_UNUSED;
        end else if (pick < 6) begin
            w = mk($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A, $urandom_range(0, 7),
                   $urandom_range(0, 7), $urandom_range(1, 65535));
        end else if (pick < 8) begin
            w = mk($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A, $urandom_range(0, 7),
                   $urandom_range(0, 7), 0);
        end else begin
            if (have_prev && $urandom_range(0, 6) == 0) begin
                w = prev_load;
            end else if (a_only || $urandom_range(0, 1) == 0) begin
                w = mk(REQ_LOAD_A, $urandom_range(0, cur_lr), $urandom_range(0, cur_li), 0);
            end else begin
                w = mk(REQ_LOAD_B, $urandom_range(0, cur_li), $urandom_range(0, cur_lc), 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                mag = $urandom_range(1, 4);
                w.elem_value = ELEM_W'($urandom_range(0, 1) ? -mag : mag);
            end else if (pick < 45) begin
                case ($urandom_range(0, 3))
                    0:       w.elem_value = 16'sh7fff;
                    1:       w.elem_value = 16'sh8000;
                    2:       w.elem_value = 16'sh0001;
                    default: w.elem_value = 16'shffff;
                endcase
            end else begin
                w.elem_value = ELEM_W'($urandom());
            end
            prev_load = w;
            have_prev = 1'b1;
        end
    endtask

    // A run of loads closed by a multiply word whose other fields carry noise.
    task automatic run_batch(input int loads, input bit a_only);
        stmm_in_t w;
        repeat (loads) begin
            make_load(a_only, w);
            offer(w);
        end
        w          = stmm_in_t'(IN_W'($urandom()));
        w.req_type = REQ_MULT;
        offer(w);
    endtask

    // Result side: stall patterns change now and then; a long hold-off runs on request.
    initial begin
        int mode;
        int mode_left;
        int holds_done;
        m_ready    = 1'b0;
        mode       = 0;
        mode_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (holds_done < hold_req_cnt) begin
                m_ready <= 1'b0;
                holds_done++;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(30, 300);
                end
                mode_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (mode_left % 5 == 0);
                endcase
            end
        end
    end

    initial begin
        stmm_in_t         directed [$];
        logic [CFG_W-1:0] lr;
        logic [CFG_W-1:0] li;
        logic [CFG_W-1:0] lc;
        int               phase;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = CFG_LAST_ROW_A;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure(3'd7, 3'd7, 3'd7);
        // Empty stores first, then extremes, a wrapping repeated position, a zero value,
        // an unused request, a product that cancels to zero and a sum that wraps 32 bits.
        directed.push_back(mk(REQ_MULT, 0, 0, 0));
        directed.push_back(mk(REQ_LOAD_A, 0, 0, 32767));
        directed.push_back(mk(REQ_LOAD_B, 0, 0, 32767));
        directed.push_back(mk(REQ_LOAD_A, 0, 7, -32768));
        directed.push_back(mk(REQ_LOAD_B, 7, 7, -32768));
        directed.push_back(mk(REQ_LOAD_A, 7, 0, 1));
        directed.push_back(mk(REQ_LOAD_A, 7, 0, 32767));
        directed.push_back(mk(REQ_LOAD_B, 0, 7, -1));
        directed.push_back(mk(REQ_LOAD_A, 3, 3, 0));
        directed.push_back(mk(REQ_UNUSED, 7, 7, -1));
        directed.push_back(mk(REQ_LOAD_B, 7, 0, 5));
        directed.push_back(mk(REQ_MULT, 7, 7, -1));
        directed.push_back(mk(REQ_LOAD_A, 1, 0, 2));
        directed.push_back(mk(REQ_LOAD_A, 1, 1, 3));
        directed.push_back(mk(REQ_LOAD_B, 0, 2, 3));
        directed.push_back(mk(REQ_LOAD_B, 1, 2, -2));
        directed.push_back(mk(REQ_MULT, 0, 0, 0));
        directed.push_back(mk(REQ_LOAD_A, 2, 0, -32768));
        directed.push_back(mk(REQ_LOAD_A, 2, 1, -32768));
        directed.push_back(mk(REQ_LOAD_B, 0, 3, -32768));
        directed.push_back(mk(REQ_LOAD_B, 1, 3, -32768));
        directed.push_back(mk(REQ_MULT, 0, 0, 0));
        foreach (directed[i]) offer(directed[i]);

        work_done = 0;
        phase     = 0;
        while (work_done < RANDOM_WORK) begin
            case (phase)
                0: begin lr = 3'd0; li = 3'd0; lc = 3'd0; end
                1: begin lr = 3'd7; li = 3'd7; lc = 3'd7; end
                2: begin lr = 3'd7; li = 3'd0; lc = 3'd7; end
                3: begin lr = 3'd0; li = 3'd7; lc = 3'd0; end
                4: begin lr = 3'd7; li = 3'd7; lc = 3'd0; end
                default: begin
                    lr = ($urandom_range(0, 3) == 0) ? 3'd7 : 3'($urandom_range(0, 7));
                    li = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(0, 7));
                    lc = ($urandom_range(0, 3) == 0) ? 3'd7 : 3'($urandom_range(0, 7));
                end
            endcase
            configure(lr, li, lc);
            if (phase == 1) begin
                // Dense stores under a long result hold-off: the multiply backs up
                // and the loads behind it must wait at the input.
                hold_req_cnt <= hold_req_cnt + 1;
                run_batch(60, 1'b0);
                run_batch(20, 1'b0);
            end
            repeat ($urandom_range(2, 5)) begin
                run_batch(($urandom_range(0, 4) == 0) ? $urandom_range(17, 30)
                                                      : $urandom_range(1, 16),
                          $urandom_range(0, 9) == 0);
            end
            phase++;
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_sparse_triple_matrix_multiply: done, clean");
        end else begin
            $display("tb_sparse_triple_matrix_multiply: done, errors");
        end
        $finish;
    end

endmodule
